[design/hsrg_pkg.sv]
`timescale 1ns / 1ps

package hsrg_pkg;

    localparam int ROW_W      = 30;
    localparam int SIZE_W     = 11;
    localparam int DIMS_W     = 2;
    localparam int SHIFT_W    = 48;
    localparam int PLANE_W    = 2 * SIZE_W;
    localparam int TOTAL_W    = 3 * SIZE_W;
    localparam int SQ_W       = 2 * (SIZE_W + 1);
    localparam int NUM_SLOTS  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SHIFT_W;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_VALUE = 3'd4;

    localparam logic [2:0] SLOT_DIAG   = 3'd0;
    localparam logic [2:0] SLOT_X_LOW  = 3'd1;
    localparam logic [2:0] SLOT_X_HIGH = 3'd2;
    localparam logic [2:0] SLOT_Y_LOW  = 3'd3;
    localparam logic [2:0] SLOT_Y_HIGH = 3'd4;
    localparam logic [2:0] SLOT_Z_LOW  = 3'd5;
    localparam logic [2:0] SLOT_Z_HIGH = 3'd6;

    typedef struct packed {
        logic [DIMS_W-1:0]  num_dims;
        logic [SIZE_W-1:0]  size_x;
        logic [SIZE_W-1:0]  size_y;
        logic [SIZE_W-1:0]  size_z;
        logic [SHIFT_W-1:0] shift_value;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic                 err;
        logic [NUM_SLOTS-1:0] mask;
        logic [SIZE_W-1:0]    sx;
        logic [PLANE_W-1:0]   plane;
    } task_t;

endpackage

[design/hsrg_fifo.sv]
`timescale 1ns / 1ps

module hsrg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/hsrg_front.sv]
`timescale 1ns / 1ps

module hsrg_front #(
    parameter int MAX_AXIS_SIZE = 1024,
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 16,
    parameter int TASK_W        = $bits(hsrg_pkg::task_t) + 4 * VALUE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  hsrg_pkg::cfg_t               cfg,
    input  logic                         push,
    input  logic [hsrg_pkg::ROW_W-1:0]   row_index,
    output logic                         full,
    output logic                         task_push,
    output logic [TASK_W-1:0]            task_data,
    input  logic                         task_full
);

    localparam int CW = (VALUE_WIDTH > 54) ? VALUE_WIDTH : 54;
    localparam int SW = hsrg_pkg::SIZE_W;
    localparam int RW = hsrg_pkg::ROW_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    localparam logic [CW-1:0] SAT_HI = {{(CW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};

    function automatic logic [VALUE_WIDTH-1:0] sat_val(input logic [CW-1:0] v);
        logic signed [CW-1:0] sv;
        logic [VALUE_WIDTH-1:0] res;
        sv = $signed(v);
        if (sv > $signed(SAT_HI))
        begin
            res = SAT_HI[VALUE_WIDTH-1:0];
        end
        else if (sv < $signed(~SAT_HI))
        begin
            res = ~SAT_HI[VALUE_WIDTH-1:0];
        end
        else
        begin
            res = v[VALUE_WIDTH-1:0];
        end
        return res;
    endfunction

    function automatic logic [SW-1:0] clamp(input logic [SW-1:0] s);
        logic [SW+1:0] lim;
        lim = (SW+2)'(MAX_AXIS_SIZE);
        return ({2'b00, s} > lim) ? SW'(MAX_AXIS_SIZE) : s;
    endfunction

    logic                 hold_valid_reg, hold_valid_next;
    logic [RW-1:0]        hold_row_reg;
    logic [1:0]           state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [31:0]          num_reg, num_next;
    logic [SW-1:0]        rem_reg, rem_next;
    logic [RW-1:0]        row_reg;
    logic [SW-1:0]        x_reg, y_reg, z_reg;

    logic [1:0]           dims_e;
    logic [SW-1:0]        sx_e, sy_e, sz_e;
    logic [SW-1:0]        divisor;
    logic [SW-1:0]        step_rem;
    logic [7:0]           step_q;
    logic [31:0]          q_full;
    logic                 load;

    logic [hsrg_pkg::SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [hsrg_pkg::PLANE_W-1:0] plane_reg;
    logic [hsrg_pkg::TOTAL_W-1:0] total_reg;
    logic [CW-1:0]                sum_reg;
    logic [CW-1:0]                hx_w, hy_w, hz_w, shift_w;
    logic [VALUE_WIDTH-1:0]       diag_v_reg, hx_v_reg, hy_v_reg, hz_v_reg;
    logic [SW:0]                  sx1, sy1, sz1;

    hsrg_pkg::task_t              task_w;

    assign dims_e = (cfg.num_dims == 2'd0) ? 2'd1 : cfg.num_dims;
    assign sx_e   = clamp(cfg.size_x);
    assign sy_e   = (dims_e >= 2'd2) ? clamp(cfg.size_y) : SW'(1);
    assign sz_e   = (dims_e >= 2'd3) ? clamp(cfg.size_z) : SW'(1);

    assign full = hold_valid_reg;
    assign load = (state_reg == ST_IDLE) && hold_valid_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (load)
        begin
            hold_valid_next = 1'b0;
        end
        if (push && !hold_valid_reg)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !hold_valid_reg)
        begin
            hold_row_reg <= row_index;
        end
    end

    // eight restoring division steps per cycle
    assign divisor = (cnt_reg < 3'd4) ? sx_e : sy_e;

    always_comb
    begin
        logic [SW:0]   t;
        logic [SW-1:0] r;
        r = rem_reg;
        step_q = '0;
        for (int i = 0; i < 8; i++)
        begin
            t = {r, num_reg[31-i]};
            if (t >= {1'b0, divisor})
            begin
                t = t - {1'b0, divisor};
                step_q[7-i] = 1'b1;
            end
            r = t[SW-1:0];
        end
        step_rem = r;
    end

    assign q_full = {num_reg[23:0], step_q};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    num_next   = {2'b00, hold_row_reg};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                begin
                    num_next = {q_full[23:0], 8'h00};
                    rem_next = '0;
                end
                else
                begin
                    num_next = q_full;
                    rem_next = step_rem;
                end
                if (cnt_reg == 3'd6)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!task_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        if (load)
        begin
            row_reg <= hold_row_reg;
        end
        if (state_reg == ST_DIV && cnt_reg == 3'd3)
        begin
            x_reg <= step_rem;
        end
        if (state_reg == ST_DIV && cnt_reg == 3'd6)
        begin
            y_reg <= step_rem;
            z_reg <= q_full[SW-1:0];
        end
    end

    // geometry and values follow the static configuration
    assign sx1 = {1'b0, sx_e} + 1'b1;
    assign sy1 = {1'b0, cfg.size_y > 11'd0 ? clamp(cfg.size_y) : 11'd0} + 1'b1;
    assign sz1 = {1'b0, clamp(cfg.size_z)} + 1'b1;

    assign hx_w    = {{(CW-hsrg_pkg::SQ_W){1'b0}}, sq_x_reg} << FRACTION_BITS;
    assign hy_w    = {{(CW-hsrg_pkg::SQ_W){1'b0}}, sq_y_reg} << FRACTION_BITS;
    assign hz_w    = {{(CW-hsrg_pkg::SQ_W){1'b0}}, sq_z_reg} << FRACTION_BITS;
    assign shift_w = {{(CW-hsrg_pkg::SHIFT_W){cfg.shift_value[hsrg_pkg::SHIFT_W-1]}},
                      cfg.shift_value};

    always_ff @(posedge clk)
    begin
        sq_x_reg   <= sx1 * sx1;
        sq_y_reg   <= (dims_e >= 2'd2) ? sy1 * sy1 : '0;
        sq_z_reg   <= (dims_e >= 2'd3) ? sz1 * sz1 : '0;
        plane_reg  <= sx_e * sy_e;
        total_reg  <= plane_reg * sz_e;
        sum_reg    <= hx_w + hy_w + hz_w;
        diag_v_reg <= sat_val((sum_reg << 1) - shift_w);
        hx_v_reg   <= sat_val(CW'(0) - hx_w);
        hy_v_reg   <= sat_val(CW'(0) - hy_w);
        hz_v_reg   <= sat_val(CW'(0) - hz_w);
    end

    always_comb
    begin
        task_w.row   = row_reg;
        task_w.err   = (total_reg == '0) || ({3'b000, row_reg} >= total_reg);
        task_w.sx    = sx_e;
        task_w.plane = plane_reg;
        if (task_w.err)
        begin
            task_w.mask = 7'b0000001;
        end
        else
        begin
            task_w.mask[hsrg_pkg::SLOT_DIAG]   = 1'b1;
            task_w.mask[hsrg_pkg::SLOT_X_LOW]  = (x_reg != '0);
            task_w.mask[hsrg_pkg::SLOT_X_HIGH] = (x_reg != sx_e - 1'b1);
            task_w.mask[hsrg_pkg::SLOT_Y_LOW]  = (dims_e >= 2'd2) && (y_reg != '0);
            task_w.mask[hsrg_pkg::SLOT_Y_HIGH] = (dims_e >= 2'd2) && (y_reg != sy_e - 1'b1);
            task_w.mask[hsrg_pkg::SLOT_Z_LOW]  = (dims_e >= 2'd3) && (z_reg != '0);
            task_w.mask[hsrg_pkg::SLOT_Z_HIGH] = (dims_e >= 2'd3) && (z_reg != sz_e - 1'b1);
        end
    end

    assign task_push = (state_reg == ST_PUSH);
    assign task_data = {task_w, diag_v_reg, hx_v_reg, hy_v_reg, hz_v_reg};

endmodule

[design/hsrg_back.sv]
`timescale 1ns / 1ps

module hsrg_back #(
    parameter int VALUE_WIDTH = 48,
    parameter int TASK_W      = $bits(hsrg_pkg::task_t) + 4 * VALUE_WIDTH,
    parameter int OUT_W       = hsrg_pkg::ROW_W + VALUE_WIDTH + 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              task_empty,
    input  logic [TASK_W-1:0] task_data,
    output logic              task_pop,
    output logic              out_push,
    output logic [OUT_W-1:0]  out_data,
    input  logic              out_full
);

    localparam int RW = hsrg_pkg::ROW_W;
    localparam int NS = hsrg_pkg::NUM_SLOTS;

    hsrg_pkg::task_t          task_reg, task_in;
    logic [VALUE_WIDTH-1:0]   diag_reg, hx_reg, hy_reg, hz_reg;
    logic [VALUE_WIDTH-1:0]   diag_in, hx_in, hy_in, hz_in;
    logic [NS-1:0]            rem_reg, rem_next;
    logic                     busy_reg, busy_next;
    logic [2:0]               slot;
    logic [NS-1:0]            rem_after;
    logic                     emit, last;
    logic [RW-1:0]            col;
    logic [VALUE_WIDTH-1:0]   val;

    assign {task_in, diag_in, hx_in, hy_in, hz_in} = task_data;

    always_comb
    begin
        slot = hsrg_pkg::SLOT_Z_HIGH;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                slot = 3'(i);
            end
        end
    end

    assign rem_after = rem_reg & ~(NS'(1) << slot);
    assign last      = (rem_after == '0);
    assign emit      = busy_reg && !out_full;
    assign task_pop  = !task_empty && (!busy_reg || (emit && last));

    always_comb
    begin
        col = task_reg.row;
        val = diag_reg;
        case (slot)
            hsrg_pkg::SLOT_DIAG:
            begin
                col = task_reg.row;
                val = diag_reg;
            end
            hsrg_pkg::SLOT_X_LOW:
            begin
                col = task_reg.row - 1'b1;
                val = hx_reg;
            end
            hsrg_pkg::SLOT_X_HIGH:
            begin
                col = task_reg.row + 1'b1;
                val = hx_reg;
            end
            hsrg_pkg::SLOT_Y_LOW:
            begin
                col = task_reg.row - RW'(task_reg.sx);
                val = hy_reg;
            end
            hsrg_pkg::SLOT_Y_HIGH:
            begin
                col = task_reg.row + RW'(task_reg.sx);
                val = hy_reg;
            end
            hsrg_pkg::SLOT_Z_LOW:
            begin
                col = task_reg.row - RW'(task_reg.plane);
                val = hz_reg;
            end
            hsrg_pkg::SLOT_Z_HIGH:
            begin
                col = task_reg.row + RW'(task_reg.plane);
                val = hz_reg;
            end
            default:
            begin
                col = task_reg.row;
                val = diag_reg;
            end
        endcase
        if (task_reg.err)
        begin
            col = '0;
            val = '0;
        end
    end

    assign out_push = emit;
    assign out_data = {col, val, last, task_reg.err};

    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        if (emit)
        begin
            rem_next  = rem_after;
            busy_next = !last;
        end
        if (task_pop)
        begin
            rem_next  = task_in.mask;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rem_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (task_pop)
        begin
            task_reg <= task_in;
            diag_reg <= diag_in;
            hx_reg   <= hx_in;
            hy_reg   <= hy_in;
            hz_reg   <= hz_in;
        end
    end

endmodule

[design/helmholtz_stencil_row_generator.sv]
`timescale 1ns / 1ps

// Stencil row generator for the shifted finite-difference Helmholtz operator.
// Input channel: push a row_index while full is low. Result channel: while
// empty is low the oldest word (column_index, entry_value, last_entry,
// row_out_of_range) is shown; pop takes it. A row yields one word per
// nonzero in the order diagonal, x-1, x+1, y-1, y+1, z-1, z+1, with
// last_entry on the final one; a row beyond the grid yields one error word.
// The front splits the row into coordinates with a shared divider that
// retires eight quotient bits a cycle: row / size_x gives x, and that
// quotient / size_y gives y and z. A hold register takes the next row while
// the last is divided. The back emits one word per cycle while the output
// queue has room; a two-entry queue lets the two run apart. Configuration
// is written through cfg_write/cfg_index/cfg_data, by the user only while
// the block is idle; the block itself does not enforce this. Reset empties all
// queues and loads num_dims=1, sizes 1, shift 0. When the receiver stalls,
// words back up in the output and middle queues and full rises once the
// front has nowhere to put its next row.
module helmholtz_stencil_row_generator #(
    parameter int MAX_AXIS_SIZE = 1024,
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [hsrg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hsrg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [hsrg_pkg::ROW_W-1:0]          row_index,
    output logic                                empty,
    input  logic                                pop,
    output logic [hsrg_pkg::ROW_W-1:0]          column_index,
    output logic signed [VALUE_WIDTH-1:0]       entry_value,
    output logic                                last_entry,
    output logic                                row_out_of_range
);

    localparam int TASK_W = $bits(hsrg_pkg::task_t) + 4 * VALUE_WIDTH;
    localparam int OUT_W  = hsrg_pkg::ROW_W + VALUE_WIDTH + 2;

    hsrg_pkg::cfg_t     cfg_reg;
    logic               task_push, task_full, task_pop, task_empty;
    logic [TASK_W-1:0]  task_wdata, task_rdata;
    logic               out_push, out_full;
    logic [OUT_W-1:0]   out_wdata, out_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_dims    <= 2'd1;
            cfg_reg.size_x      <= 11'd1;
            cfg_reg.size_y      <= 11'd1;
            cfg_reg.size_z      <= 11'd1;
            cfg_reg.shift_value <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hsrg_pkg::REG_NUM_DIMS:    cfg_reg.num_dims    <= cfg_data[1:0];
                hsrg_pkg::REG_SIZE_X:      cfg_reg.size_x      <= cfg_data[10:0];
                hsrg_pkg::REG_SIZE_Y:      cfg_reg.size_y      <= cfg_data[10:0];
                hsrg_pkg::REG_SIZE_Z:      cfg_reg.size_z      <= cfg_data[10:0];
                hsrg_pkg::REG_SHIFT_VALUE: cfg_reg.shift_value <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    hsrg_front #(
        .MAX_AXIS_SIZE (MAX_AXIS_SIZE),
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .TASK_W        (TASK_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .row_index (row_index),
        .full      (full),
        .task_push (task_push),
        .task_data (task_wdata),
        .task_full (task_full)
    );

    hsrg_fifo #(
        .WIDTH (TASK_W),
        .DEPTH (2)
    ) u_task_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (task_push),
        .push_data (task_wdata),
        .full      (task_full),
        .pop       (task_pop),
        .pop_data  (task_rdata),
        .empty     (task_empty)
    );

    hsrg_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .TASK_W      (TASK_W),
        .OUT_W       (OUT_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_empty (task_empty),
        .task_data  (task_rdata),
        .task_pop   (task_pop),
        .out_push   (out_push),
        .out_data   (out_wdata),
        .out_full   (out_full)
    );

    hsrg_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (2)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_wdata),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_rdata),
        .empty     (empty)
    );

    assign {column_index, entry_value, last_entry, row_out_of_range} = out_rdata;

endmodule

[design/hsrg_checker.sv]
`timescale 1ns / 1ps

module hsrg_checker #(
    parameter int VALUE_WIDTH = 48
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          full,
    input logic                          pop,
    input logic                          empty,
    input logic [hsrg_pkg::ROW_W-1:0]    column_index,
    input logic [VALUE_WIDTH-1:0]        entry_value,
    input logic                          last_entry,
    input logic                          row_out_of_range
);

    a_reset_clear: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not clear after reset");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_out_of_range) |-> last_entry)
        else $error("error word without last_entry");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_out_of_range) |-> (column_index == '0 && entry_value == '0))
        else $error("error word carries data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(column_index) && $stable(entry_value)
                              && $stable(last_entry)))
        else $error("stalled word changed");

endmodule

bind helmholtz_stencil_row_generator hsrg_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_hsrg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .full             (full),
    .pop              (pop),
    .empty            (empty),
    .column_index     (column_index),
    .entry_value      (entry_value),
    .last_entry       (last_entry),
    .row_out_of_range (row_out_of_range)
);
